// ----- hdl/line_centroid_steering_assert.svh -----
// Assertion macros for the line centroid steering block.
// Used by the port checker; no other dependencies.
`ifndef LINE_CENTROID_STEERING_ASSERT_SVH
`define LINE_CENTROID_STEERING_ASSERT_SVH

// Same-cycle implication, gated off while rst is high
`define LCS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated off while rst is high
`define LCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/lcs_pkg.sv -----
// Shared types and constants for the line centroid steering block.
// No dependencies.
package lcs_pkg;

   // Default row length limit
   localparam int MAX_ROW_PIXELS_DEF = 1024;

   // Three-level clip thresholds on the inverted gray level
   localparam logic [7:0] CLIP_LO   = 8'd85;
   localparam logic [7:0] CLIP_HI   = 8'd171;
   localparam logic [7:0] PIXEL_MAX = 8'd255;

   // Offset quotient bits (Q1.15) and the one-half bias
   localparam int                 OFFSET_BITS = 15;
   localparam logic signed [15:0] OFFSET_HALF = 16'sd16384;

   // Request queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

   // CSR map
   localparam int         CSR_INDEX_BITS    = 2;
   localparam logic [1:0] CSR_RIGHT_TARGET  = 2'd0;
   localparam logic [1:0] CSR_LEFT_TARGET   = 2'd1;
   localparam logic [1:0] CSR_DONE_TOL      = 2'd2;
   localparam logic [1:0] CSR_STEER_TRIM    = 2'd3;

   localparam logic [30:0] DONE_TOL_RESET   = 31'd655;
   localparam logic [15:0] STEER_TRIM_RESET = 16'd1311;

   typedef struct packed {
      logic [7:0]         pixel_gray;
      logic               last_pixel;
      logic signed [31:0] right_position;
      logic signed [31:0] left_position;
      logic signed [31:0] right_speed;
      logic signed [31:0] left_speed;
   } req_type;

   typedef struct packed {
      logic               move_done;
      logic               line_found;
      logic signed [15:0] line_offset;
      logic signed [31:0] right_speed_cmd;
      logic signed [31:0] left_speed_cmd;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] right_target;
      logic signed [31:0] left_target;
      logic [30:0]        done_tolerance;
      logic [15:0]        steer_trim;
   } cfg_type;

endpackage

// ----- hdl/lcs_front.sv -----
// Front end: clips pixels and accumulates weight and moment over a row.
// Depends on lcs_pkg; pushes one row summary per last pixel.
module lcs_front #(
   parameter int MaxRowPixels = lcs_pkg::MAX_ROW_PIXELS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lcs_pkg::req_type req_data,
   output logic             push_valid,
   input  logic             push_full,
   output logic [$clog2(MaxRowPixels+1)*4+16+127:0] push_data
);

   localparam int IW = $clog2(MaxRowPixels + 1);
   localparam int WW = IW + 8;
   localparam int MW = 2 * IW + 8;

   logic [WW-1:0] weight_ff, weight_in, weight_acc;
   logic [MW-1:0] moment_ff, moment_in, moment_acc;
   logic [IW-1:0] index_ff, index_in, index_acc;
   logic [7:0]    inv_gray;
   logic [7:0]    pix_weight;
   logic          in_range;
   logic          req_fire;

   // A last pixel needs a queue slot; other pixels always go through
   assign req_ready = !req_data.last_pixel || !push_full;
   assign req_fire  = req_valid && req_ready;

   // Invert and clip
   always_comb begin
      inv_gray = lcs_pkg::PIXEL_MAX - req_data.pixel_gray;
      if (inv_gray inside {[8'd0:lcs_pkg::CLIP_LO]}) begin
         pix_weight = 8'd0;
      end else if (inv_gray inside {[lcs_pkg::CLIP_HI:lcs_pkg::PIXEL_MAX]}) begin
         pix_weight = lcs_pkg::PIXEL_MAX;
      end else begin
         pix_weight = inv_gray;
      end
   end

   // Accumulate; pixels past the row limit are dropped
   always_comb begin
      in_range   = index_ff < IW'(MaxRowPixels);
      weight_acc = weight_ff;
      moment_acc = moment_ff;
      index_acc  = index_ff;
      if (in_range) begin
         weight_acc = weight_ff + WW'(pix_weight);
         moment_acc = moment_ff + MW'(pix_weight) * MW'(index_ff);
         index_acc  = index_ff + IW'(1);
      end
      weight_in = weight_ff;
      moment_in = moment_ff;
      index_in  = index_ff;
      if (req_fire) begin
         if (req_data.last_pixel) begin
            weight_in = '0;
            moment_in = '0;
            index_in  = '0;
         end else begin
            weight_in = weight_acc;
            moment_in = moment_acc;
            index_in  = index_acc;
         end
      end
   end

   // Row summary for the back end
   assign push_valid = req_fire && req_data.last_pixel;
   assign push_data  = {weight_acc, moment_acc, index_acc,
                        req_data.right_position, req_data.left_position,
                        req_data.right_speed, req_data.left_speed};

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
         moment_ff <= '0;
         index_ff  <= '0;
      end else begin
         weight_ff <= weight_in;
         moment_ff <= moment_in;
         index_ff  <= index_in;
      end
   end

endmodule

// ----- hdl/lcs_queue.sv -----
// Short FIFO between front and back ends.
// Depends on lcs_pkg for its depth.
module lcs_queue #(
   parameter int Width = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_full,
   input  logic [Width-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [Width-1:0] pop_data
);

   localparam int Depth = lcs_pkg::QUEUE_DEPTH;
   localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CW    = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_full = count_ff == CW'(Depth);
   assign pop_valid = count_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_valid && pop_ready;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(Depth - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(Depth - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/lcs_back.sv -----
// Back end: divides out the centroid, checks completion, forms speed commands.
// Depends on lcs_pkg; holds the result register.
module lcs_back #(
   parameter int MaxRowPixels = lcs_pkg::MAX_ROW_PIXELS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  lcs_pkg::cfg_type cfg,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  logic [$clog2(MaxRowPixels+1)*4+16+127:0] pop_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lcs_pkg::rsp_type rsp_data
);

   localparam int IW = $clog2(MaxRowPixels + 1);
   localparam int WW = IW + 8;
   localparam int MW = 2 * IW + 8;
   localparam int DW = WW + IW;
   localparam int SW = $clog2(lcs_pkg::OFFSET_BITS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [1:0]     state_ff, state_in;
   logic [WW-1:0]  weight_ff, weight_in;
   logic [MW-1:0]  moment_ff, moment_in;
   logic [IW-1:0]  width_ff, width_in;
   logic signed [31:0] rpos_ff, rpos_in, lpos_ff, lpos_in;
   logic signed [31:0] rspd_ff, rspd_in, lspd_ff, lspd_in;
   logic [DW-1:0]  den_ff, den_in;
   logic signed [33:0] diff_ff, diff_in;
   logic signed [31:0] mean_ff, mean_in;
   logic [DW:0]    rem_ff, rem_in;
   logic [lcs_pkg::OFFSET_BITS-1:0] quot_ff, quot_in;
   logic [SW-1:0]  step_ff, step_in;
   logic           found_ff, found_in;
   logic           gt_ff, gt_in;
   logic           done_ff, done_in;
   logic           rsp_valid_ff, rsp_valid_in;
   lcs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic signed [32:0] spd_sum;
   logic [DW:0]        rem_shift;
   logic [33:0]        diff_abs;
   logic signed [33:0] trim_ext;
   logic signed [33:0] mean_ext;
   logic signed [33:0] cmd_up, cmd_dn;
   logic signed [31:0] cmd_up_sat, cmd_dn_sat;
   logic               out_free;

   assign pop_ready = state_ff == ST_IDLE;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Helpers for the division step and the speed commands
   always_comb begin
      spd_sum   = 33'(rspd_ff) + 33'(lspd_ff);
      rem_shift = {rem_ff[DW-1:0], 1'b0};
      diff_abs  = diff_ff[33] ? 34'(-diff_ff) : 34'(diff_ff);
      trim_ext  = 34'(signed'({1'b0, cfg.steer_trim}));
      mean_ext  = 34'(mean_ff);
      cmd_up    = mean_ext + trim_ext;
      cmd_dn    = mean_ext - trim_ext;
      cmd_up_sat = (cmd_up > 34'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF : cmd_up[31:0];
      cmd_dn_sat = (cmd_dn < -34'sh0_8000_0000) ? 32'sh8000_0000 : cmd_dn[31:0];
   end

   // Sequencer: load, multiply, divide bit by bit, finish
   always_comb begin
      state_in     = state_ff;
      weight_in    = weight_ff;
      moment_in    = moment_ff;
      width_in     = width_ff;
      rpos_in      = rpos_ff;
      lpos_in      = lpos_ff;
      rspd_in      = rspd_ff;
      lspd_in      = lspd_ff;
      den_in       = den_ff;
      diff_in      = diff_ff;
      mean_in      = mean_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      gt_in        = gt_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               {weight_in, moment_in, width_in, rpos_in, lpos_in, rspd_in, lspd_in} =
                  pop_data;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            den_in   = DW'(weight_ff) * DW'(width_ff);
            diff_in  = (34'(cfg.right_target) - 34'(rpos_ff))
                     + (34'(cfg.left_target) - 34'(lpos_ff));
            // halve toward zero
            mean_in  = 32'((spd_sum + 33'(signed'({1'b0, spd_sum[32]}))) >>> 1);
            found_in = (moment_ff != '0) && (weight_ff != '0) && (width_ff != '0);
            rem_in   = (DW + 1)'(moment_ff);
            quot_in  = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (step_ff == '0) begin
               gt_in   = {1'b0, moment_ff, 1'b0} > (MW + 2)'(den_ff);
               done_in = diff_abs < {2'b00, cfg.done_tolerance, 1'b0};
            end
            if (rem_shift >= {1'b0, den_ff}) begin
               rem_in  = rem_shift - {1'b0, den_ff};
               quot_in = {quot_ff[lcs_pkg::OFFSET_BITS-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               quot_in = {quot_ff[lcs_pkg::OFFSET_BITS-2:0], 1'b0};
            end
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(lcs_pkg::OFFSET_BITS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.move_done = done_ff;
               if (done_ff) begin
                  rsp_data_in.line_found      = 1'b0;
                  rsp_data_in.line_offset     = '0;
                  rsp_data_in.right_speed_cmd = '0;
                  rsp_data_in.left_speed_cmd  = '0;
               end else if (!found_ff) begin
                  rsp_data_in.line_found      = 1'b0;
                  rsp_data_in.line_offset     = '0;
                  rsp_data_in.right_speed_cmd = mean_ff;
                  rsp_data_in.left_speed_cmd  = mean_ff;
               end else begin
                  rsp_data_in.line_found  = 1'b1;
                  rsp_data_in.line_offset = signed'({1'b0, quot_ff}) - lcs_pkg::OFFSET_HALF;
                  // line right of center: slow the right wheel
                  if (gt_ff) begin
                     rsp_data_in.right_speed_cmd = cmd_dn_sat;
                     rsp_data_in.left_speed_cmd  = cmd_up_sat;
                  end else begin
                     rsp_data_in.right_speed_cmd = cmd_up_sat;
                     rsp_data_in.left_speed_cmd  = cmd_dn_sat;
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      weight_ff   <= weight_in;
      moment_ff   <= moment_in;
      width_ff    <= width_in;
      rpos_ff     <= rpos_in;
      lpos_ff     <= lpos_in;
      rspd_ff     <= rspd_in;
      lspd_ff     <= lspd_in;
      den_ff      <= den_in;
      diff_ff     <= diff_in;
      mean_ff     <= mean_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      found_ff    <= found_in;
      gt_ff       <= gt_in;
      done_ff     <= done_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- hdl/line_centroid_steering.sv -----
// From the last pixel to result valid: load, multiply, 15-step restoring divide, finish,
// plus any wait for rsp_ready or an earlier row. One pixel per cycle while the queue has
// room for a last pixel; the back end takes a new row summary only once the bit-serial
// divider has finished the last. A 2-entry queue holds row summaries between the two ends.
// Reset (synchronous, active high) clears accumulators, queue, sequencer, the
// result valid flag and returns the CSRs to their default values.
module line_centroid_steering #(
   parameter int MaxRowPixels = lcs_pkg::MAX_ROW_PIXELS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lcs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lcs_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [lcs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [31:0]      csr_wdata
);

   localparam int EW = $clog2(MaxRowPixels + 1) * 4 + 16 + 128;

   lcs_pkg::cfg_type cfg_ff, cfg_in;
   logic             push_valid, push_full;
   logic [EW-1:0]    push_data;
   logic             pop_valid, pop_ready;
   logic [EW-1:0]    pop_data;

   // CSR writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lcs_pkg::CSR_RIGHT_TARGET: cfg_in.right_target   = signed'(csr_wdata);
            lcs_pkg::CSR_LEFT_TARGET:  cfg_in.left_target    = signed'(csr_wdata);
            lcs_pkg::CSR_DONE_TOL:     cfg_in.done_tolerance = csr_wdata[30:0];
            lcs_pkg::CSR_STEER_TRIM:   cfg_in.steer_trim     = csr_wdata[15:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.right_target   <= '0;
         cfg_ff.left_target    <= '0;
         cfg_ff.done_tolerance <= lcs_pkg::DONE_TOL_RESET;
         cfg_ff.steer_trim     <= lcs_pkg::STEER_TRIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcs_front #(.MaxRowPixels(MaxRowPixels)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data)
   );

   lcs_queue #(.Width(EW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   lcs_back #(.MaxRowPixels(MaxRowPixels)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hdl/lcs_checker.sv -----
// Port-level checks on the line centroid steering block, bound to the top.
// Depends on lcs_pkg and line_centroid_steering_assert.svh.
`include "line_centroid_steering_assert.svh"

module lcs_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lcs_pkg::rsp_type rsp_data
);

   // A stalled result holds
   `LCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // Finished move stops both wheels and reports no line
   `LCS_ASSERT_IMPLY(a_done_stop, clock, reset, rsp_valid && rsp_data.move_done, !rsp_data.line_found && rsp_data.right_speed_cmd == 32'sd0 && rsp_data.left_speed_cmd == 32'sd0, "done result not stopped")

   // Offset is within a half and zero without a line
   `LCS_ASSERT_IMPLY(a_offset_range, clock, reset, rsp_valid, rsp_data.line_offset[15] == rsp_data.line_offset[14] && (rsp_data.line_found || rsp_data.line_offset == 16'sd0), "offset out of range")

   // No result right after reset
   `LCS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

endmodule

bind line_centroid_steering lcs_checker u_lcs_checker (.*);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for line_centroid_steering: pixel rows go in, steering commands
// come out and are compared field by field with a predictor kept in step with the CSRs.
// Depends on lcs_pkg and the line_centroid_steering RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASES         = 6;
   localparam int PHASE_PIXELS   = 100;
   localparam int LONG_ROW_PHASE = 4;
   localparam int DIRECTED_COUNT = 24;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam lcs_pkg::rsp_type NO_RSP = '0;

   typedef enum {ROW_NOISE, ROW_LINE, ROW_BLANK} row_shape_type;

   typedef struct packed {
      lcs_pkg::req_type pixel;
      logic             typed;
      lcs_pkg::rsp_type want;
   } directed_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   lcs_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   lcs_pkg::rsp_type rsp_data;
   logic    csr_we;
   logic [lcs_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [31:0] csr_wdata;

   // Predictor state and CSR shadow
   longint  row_weight;
   longint  row_moment;
   longint  row_pixels;
   lcs_pkg::cfg_type steer_cfg;

   lcs_pkg::rsp_type due_commands [$];
   int      error_count = 0;
   int      cycle_count = 0;
   int      sent_pixels;
   int      quiet_pixels;
   int      ready_hold = 0;

   logic signed [31:0] corner_speeds [4] = '{S32_MAX, S32_MIN, 32'sd0, -32'sd1};

   // Directed rows: expectations typed in where they are obvious, else predicted
   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      // right after reset: on target, move done
      '{'{8'd255, 1'b1, 32'sd0, 32'sd0, 32'sd100, 32'sd200}, 1'b1,
        '{1'b1, 1'b0, 16'sd0, 32'sd0, 32'sd0}},
      // far off target, top speeds, single dark pixel at index 0 (no moment)
      '{'{8'd0, 1'b1, S32_MAX, S32_MAX, S32_MAX, S32_MAX}, 1'b1,
        '{1'b0, 1'b0, 16'sd0, S32_MAX, S32_MAX}},
      '{'{8'd128, 1'b1, S32_MIN, S32_MIN, S32_MIN, S32_MIN}, 1'b1,
        '{1'b0, 1'b0, 16'sd0, S32_MIN, S32_MIN}},
      // tolerance boundary: just inside, then exactly on it
      '{'{8'd255, 1'b1, -32'sd1309, 32'sd0, 32'sd0, 32'sd0}, 1'b1,
        '{1'b1, 1'b0, 16'sd0, 32'sd0, 32'sd0}},
      '{'{8'd255, 1'b1, -32'sd1310, 32'sd0, -32'sd3, 32'sd0}, 1'b1,
        '{1'b0, 1'b0, 16'sd0, -32'sd1, -32'sd1}},
      // line exactly centered: zero offset, non-positive branch
      '{'{8'd255, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd0, 1'b1, 32'sd1000000, 32'sd0, 32'sd65536, 32'sd65536}, 1'b0, NO_RSP},
      // line left of center
      '{'{8'd200, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd0, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd255, 1'b1, 32'sh1234_5678, 32'sd0, 32'sd1000, 32'sd3000}, 1'b0, NO_RSP},
      // line right of center, left command saturates high
      '{'{8'd255, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd255, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd0, 1'b1, 32'sh4000_0000, 32'sd0, S32_MAX, S32_MAX}, 1'b0, NO_RSP},
      // line left, left command saturates low
      '{'{8'd255, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd0, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd255, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd255, 1'b1, 32'sh0001_0000, 32'sh0001_0000, S32_MIN, S32_MIN}, 1'b0, NO_RSP},
      // clip thresholds on both sides of each level
      '{'{8'd86, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd170, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd169, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd84, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd85, 1'b1, 32'sh7000_0000, 32'sd0, 32'sd5, -32'sd8}, 1'b0, NO_RSP},
      // light row of two pixels: no line, mean speed
      '{'{8'd171, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0}, 1'b0, NO_RSP},
      '{'{8'd255, 1'b1, 32'sd123456, 32'sd0, 32'sd10, 32'sd20}, 1'b1,
        '{1'b0, 1'b0, 16'sd0, 32'sd15, 32'sd15}}
   };

   line_centroid_steering dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic signed [31:0] clamp_s32(input longint v);
      if (v > longint'(S32_MAX)) return S32_MAX;
      if (v < longint'(S32_MIN)) return S32_MIN;
      return v[31:0];
   endfunction

   // Accumulate one pixel; on the last pixel of a row produce the steering command
   function automatic bit predict_steering(input lcs_pkg::req_type r,
                                           output lcs_pkg::rsp_type cmd);
      logic [7:0] shade;
      longint     den;
      longint     distance;
      longint     mean;
      longint     offs;
      longint     trim;
      shade = 8'd255 - r.pixel_gray;
      if (shade <= lcs_pkg::CLIP_LO) shade = 8'd0;
      else if (shade >= lcs_pkg::CLIP_HI) shade = lcs_pkg::PIXEL_MAX;
      if (row_pixels < lcs_pkg::MAX_ROW_PIXELS_DEF) begin
         row_weight += shade;
         row_moment += longint'(shade) * row_pixels;
         row_pixels++;
      end
      cmd = '0;
      if (!r.last_pixel) return 1'b0;

      distance = (longint'($signed(steer_cfg.right_target)) - longint'($signed(r.right_position)))
               + (longint'($signed(steer_cfg.left_target)) - longint'($signed(r.left_position)));
      if (distance < 0) distance = -distance;
      if (distance < 2 * longint'(steer_cfg.done_tolerance)) begin
         cmd.move_done = 1'b1;
      end else begin
         mean = (longint'($signed(r.right_speed)) + longint'($signed(r.left_speed))) / 2;
         trim = longint'(steer_cfg.steer_trim);
         cmd.right_speed_cmd = clamp_s32(mean);
         cmd.left_speed_cmd  = clamp_s32(mean);
         if (row_moment != 0) begin
            den  = row_weight * row_pixels;
            offs = (row_moment * 32768) / den - 16384;
            cmd.line_found  = 1'b1;
            cmd.line_offset = offs[15:0];
            if (row_moment * 2 > den) begin
               cmd.right_speed_cmd = clamp_s32(mean - trim);
               cmd.left_speed_cmd  = clamp_s32(mean + trim);
            end else begin
               cmd.right_speed_cmd = clamp_s32(mean + trim);
               cmd.left_speed_cmd  = clamp_s32(mean - trim);
            end
         end
      end
      row_weight = 0;
      row_moment = 0;
      row_pixels = 0;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch @%0d: %s", cycle_count, msg);
   endtask

   task automatic check_field(input string name, input longint got, input longint want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // Drive one request, wait for acceptance, then idle a random gap
   task automatic send_pixel(input lcs_pkg::req_type r, input logic typed,
                             input lcs_pkg::rsp_type typed_want);
      lcs_pkg::rsp_type predicted;
      int      gap;
      int      pick;
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (predict_steering(r, predicted))
         due_commands.push_back(typed ? typed_want : predicted);
      sent_pixels++;

      pick = $urandom_range(0, 99);
      if (quiet_pixels > 0) begin
         quiet_pixels--;
         gap = 0;
      end else if (pick < 2) begin
         quiet_pixels = $urandom_range(30, 150);
         gap = 0;
      end else if (pick < 55) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // One full row; the last pixel sometimes lands near the targets
   task automatic send_row(input int len, input row_shape_type shape);
      lcs_pkg::req_type r;
      int      band_lo;
      int      band_hi;
      logic    near;
      longint  spread;
      band_lo = $urandom_range(0, len - 1);
      band_hi = band_lo + $urandom_range(0, 6);
      near    = ($urandom_range(0, 3) == 0);
      spread  = 2 * longint'(steer_cfg.done_tolerance) + 2;
      if (spread > (longint'(1) << 30)) spread = longint'(1) << 30;
      for (int i = 0; i < len; i++) begin
         r.right_position = $urandom;
         r.left_position  = $urandom;
         r.right_speed    = $urandom;
         r.left_speed     = $urandom;
         case (shape)
            ROW_NOISE: r.pixel_gray = 8'($urandom_range(0, 255));
            // dark band on light ground; pixels past the row limit are dark too
            ROW_LINE: begin
               if ((i >= band_lo && i <= band_hi) || i >= lcs_pkg::MAX_ROW_PIXELS_DEF)
                  r.pixel_gray = 8'($urandom_range(0, 90));
               else
                  r.pixel_gray = 8'($urandom_range(160, 255));
            end
            default: r.pixel_gray = 8'($urandom_range(170, 255));
         endcase
         r.last_pixel = (i == len - 1);
         if (r.last_pixel) begin
            if ($urandom_range(0, 7) == 0) begin
               r.right_speed = corner_speeds[$urandom_range(0, 3)];
               r.left_speed  = corner_speeds[$urandom_range(0, 3)];
            end
            if (near) begin
               r.right_position = 32'($signed(steer_cfg.right_target)
                  - (longint'($urandom_range(0, 32'(2 * spread))) - spread));
               r.left_position  = 32'($signed(steer_cfg.left_target)
                  - (longint'($urandom_range(0, 32'(2 * spread))) - spread));
            end
         end
         send_pixel(r, 1'b0, NO_RSP);
      end
   endtask

   // Hold off requests until every pending command is back, then let the block settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (due_commands.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lcs_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Upper bits beyond each register's width are random and must be ignored
   task automatic apply_settings(input lcs_pkg::cfg_type c);
      write_csr(lcs_pkg::CSR_RIGHT_TARGET, c.right_target);
      write_csr(lcs_pkg::CSR_LEFT_TARGET, c.left_target);
      write_csr(lcs_pkg::CSR_DONE_TOL, {1'($urandom), c.done_tolerance});
      write_csr(lcs_pkg::CSR_STEER_TRIM, {16'($urandom), c.steer_trim});
      csr_we <= 1'b0;
      steer_cfg = c;
   endtask

   // Result side: random backpressure, short stalls mostly, some long, some free runs
   always @(posedge clock) begin : rsp_backpressure
      if (ready_hold != 0) begin
         ready_hold--;
      end else if (rsp_ready && $urandom_range(0, 9) < 7) begin
         rsp_ready <= 1'b0;
         ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 50) : $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
         ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 30);
      end
   end

   // Compare every accepted command with the oldest pending one
   always @(posedge clock) begin : rsp_monitor
      lcs_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (due_commands.size() == 0) begin
            report_mismatch("steering command with none pending");
         end else begin
            want = due_commands.pop_front();
            check_field("move_done", rsp_data.move_done, want.move_done);
            check_field("line_found", rsp_data.line_found, want.line_found);
            check_field("line_offset", rsp_data.line_offset, want.line_offset);
            check_field("right_speed_cmd", rsp_data.right_speed_cmd, want.right_speed_cmd);
            check_field("left_speed_cmd", rsp_data.left_speed_cmd, want.left_speed_cmd);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin : stimulus
      lcs_pkg::cfg_type c;
      int            phase_end;
      int            len;
      int            pick;
      row_shape_type shape;
      logic          long_sent;
      logic          paused;

      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_we       <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      row_weight   = 0;
      row_moment   = 0;
      row_pixels   = 0;
      sent_pixels  = 0;
      quiet_pixels = 0;
      long_sent    = 1'b0;
      paused       = 1'b0;
      steer_cfg    = '{32'sd0, 32'sd0, lcs_pkg::DONE_TOL_RESET, lcs_pkg::STEER_TRIM_RESET};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed rows with the reset register values
      foreach (directed_rows[k])
         send_pixel(directed_rows[k].pixel, directed_rows[k].typed, directed_rows[k].want);
      drain_results();

      // Random rows under a sequence of register settings, extremes first
      for (int p = 1; p <= PHASES; p++) begin
         case (p)
            1: c = '{S32_MAX, S32_MAX, 31'd0, 16'hFFFF};
            2: c = '{S32_MIN, S32_MIN, 31'h7FFF_FFFF, 16'd0};
            default: begin
               c.right_target   = $urandom;
               c.left_target    = $urandom;
               c.done_tolerance = 31'($urandom_range(0, 1 << 20));
               c.steer_trim     = 16'($urandom_range(0, 65535));
            end
         endcase
         apply_settings(c);
         phase_end = sent_pixels + PHASE_PIXELS;
         while (sent_pixels < phase_end || (p == LONG_ROW_PHASE && !long_sent)) begin
            if (p == LONG_ROW_PHASE && !long_sent) begin
               // overlong row: pixels past the limit must be dropped
               send_row(lcs_pkg::MAX_ROW_PIXELS_DEF + $urandom_range(1, 8), ROW_LINE);
               long_sent = 1'b1;
            end else begin
               len  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                 : $urandom_range(9, 40);
               pick = $urandom_range(0, 9);
               shape = (pick < 6) ? ROW_LINE : (pick < 9) ? ROW_NOISE : ROW_BLANK;
               send_row(len, shape);
            end
            if (p == 3 && !paused && sent_pixels > phase_end - PHASE_PIXELS / 2) begin
               drain_results();
               paused = 1'b1;
            end
         end
         drain_results();
      end

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/lcs_pkg.sv
hdl/lcs_front.sv
hdl/lcs_queue.sv
hdl/lcs_back.sv
hdl/line_centroid_steering.sv
hdl/lcs_checker.sv
tb/sv/testbench.sv
